// ----- src/rod_bending_energy_accumulator_top_assert.svh -----
// Assertion macros for the bending energy accumulator controller
`ifndef ROD_BENDING_ENERGY_ACCUMULATOR_TOP_ASSERT_SVH
`define ROD_BENDING_ENERGY_ACCUMULATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define RBEA_AST_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define RBEA_AST_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rbea_pkg.sv -----
// Types, constants and helpers for the bending energy accumulator
`default_nettype none
package rbea_pkg;

    localparam int ACC_W = 116;  // holds cross, dot, denominator and stiffness product
    localparam int DEN_W = 70;
    localparam int KB_W  = 40;
    localparam int SQ_W  = 82;
    localparam int OPD_W = 34;
    localparam int CR_W  = 68;
    localparam int N_W   = 114;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        edge_rest_length;
        logic [31:0]        voronoi_len;
        logic [31:0]        stiffness;
        logic               is_last;
    } in_item_t;

    typedef struct packed {
        logic [62:0] energy;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [2:0] {
        OPD_PE, OPD_CE, OPD_PREST, OPD_CREST, OPD_KLO, OPD_KHI, OPD_SQ, OPD_STIFF
    } opd_t;

    typedef enum logic [2:0] {
        SH_0, SH_21, SH_32, SH_40, SH_64
    } sh_t;

    typedef struct packed {
        logic       in_ld;
        logic       mac_en;
        logic       mac_clr;
        logic       mac_sub;
        opd_t       a_sel;
        logic [1:0] a_idx;
        opd_t       b_sel;
        logic [1:0] b_idx;
        sh_t        sh;
        logic       den_ld;
        logic       div_ld_k;
        logic       div_ld_t;
        logic       div_step;
        logic       k_st;
        logic [1:0] k_idx;
        logic       sq_ld;
        logic       term_add;
        logic       flag_zero;
        logic       state_upd;
        logic       out_ld;
    } cmd_t;

    typedef struct packed {
        logic [1:0] pseen;
        logic       cur_last;
        logic       skip;
        logic       out_free;
    } sts_t;

    // dividend bits of one curvature component: |cross| scaled by 2^(F+1)
    function automatic int kb_nw(int f);
        return CR_W + f + 1;
    endfunction

    // dividend bits of the energy term
    function automatic int t_nw(int f);
        return N_W + ((2 * f < 32) ? (32 - 2 * f) : 0);
    endfunction

endpackage
`default_nettype wire

// ----- src/rbea_datapath.sv -----
// Datapath: point state, shared multiply-accumulate, bit-serial divider, energy sum
`default_nettype none
module rbea_datapath
    import rbea_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire in_item_t  s_data,
    input  wire cmd_t      cmd,
    output sts_t           sts,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int KB_NW = kb_nw(FRAC_BITS);
    localparam int T_NW  = t_nw(FRAC_BITS);
    localparam int DIV_W = (KB_NW > T_NW) ? KB_NW : T_NW;
    localparam int TSH_R = (2 * FRAC_BITS >= 32) ? (2 * FRAC_BITS - 32) : 0;
    localparam int TSH_L = (2 * FRAC_BITS < 32) ? (32 - 2 * FRAC_BITS) : 0;

    logic signed [31:0] ppt_reg [3];
    logic signed [32:0] ped_reg [3];
    logic signed [31:0] cpt_reg [3];
    logic signed [32:0] ced_reg [3];
    logic [31:0] prest_reg, pvor_reg, pstf_reg;
    logic [31:0] crest_reg, cvor_reg, cstf_reg;
    logic        clast_reg;
    logic [62:0] esum_reg;
    logic [1:0]  pseen_reg, flags_reg;

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0]        acc_abs;
    logic [DEN_W-1:0]        den_reg, dsr_reg, rem_reg;
    logic [DIV_W-1:0]        dvd_reg;
    logic [62:0]             quo_reg;
    logic                    qovf_reg;
    logic [KB_W-1:0]         k_reg [3];
    logic [SQ_W-1:0]         sq_reg;
    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    logic signed [31:0]        pin [3];
    logic signed [OPD_W-1:0]   opa, opb;
    logic signed [2*OPD_W-1:0] prod;
    logic signed [ACC_W-1:0]   prod_ext, prod_sh, acc_base;
    logic [DEN_W:0]            r2;
    logic                      qbit;
    logic                      k_sat;
    logic [63:0]               sum_w;
    logic [DIV_W-1:0]          kdvd, tdvd;

    function automatic logic signed [OPD_W-1:0] opd_val(opd_t sel, logic [1:0] idx);
        logic signed [OPD_W-1:0] v;
        v = '0;
        unique case (sel)
            OPD_PE:    v = OPD_W'(ped_reg[idx]);
            OPD_CE:    v = OPD_W'(ced_reg[idx]);
            OPD_PREST: v = signed'({2'b00, prest_reg});
            OPD_CREST: v = signed'({2'b00, crest_reg});
            OPD_KLO:   v = signed'({14'd0, k_reg[idx][19:0]});
            OPD_KHI:   v = signed'({14'd0, k_reg[idx][39:20]});
            OPD_SQ: begin
                priority if (idx == 2'd0) v = signed'({2'b00, sq_reg[31:0]});
                else if (idx == 2'd1)     v = signed'({2'b00, sq_reg[63:32]});
                else                      v = signed'({16'd0, sq_reg[81:64]});
            end
            OPD_STIFF: v = signed'({2'b00, pstf_reg});
        endcase
        return v;
    endfunction

    always_comb begin
        pin[0] = s_data.pos_x;
        pin[1] = s_data.pos_y;
        pin[2] = s_data.pos_z;

        opa      = opd_val(cmd.a_sel, cmd.a_idx);
        opb      = opd_val(cmd.b_sel, cmd.b_idx);
        prod     = opa * opb;
        prod_ext = ACC_W'(prod);
        unique case (cmd.sh)
            SH_0:    prod_sh = prod_ext;
            SH_21:   prod_sh = prod_ext <<< 21;
            SH_32:   prod_sh = prod_ext <<< 32;
            SH_40:   prod_sh = prod_ext <<< 40;
            SH_64:   prod_sh = prod_ext <<< 64;
            default: prod_sh = prod_ext;
        endcase
        acc_base = cmd.mac_clr ? '0 : acc_reg;
        acc_next = cmd.mac_sub ? (acc_base - prod_sh) : (acc_base + prod_sh);

        acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

        r2   = {rem_reg, dvd_reg[DIV_W-1]};
        qbit = (r2 >= {1'b0, dsr_reg});

        k_sat = qovf_reg || (|quo_reg[62:KB_W]);
        sum_w = {1'b0, esum_reg} + {1'b0, quo_reg};

        kdvd = DIV_W'({acc_abs[CR_W-1:0], {(FRAC_BITS + 1){1'b0}}}) << (DIV_W - KB_NW);
        tdvd = ((DIV_W'(acc_abs[N_W-1:0]) >> TSH_R) << TSH_L) << (DIV_W - T_NW);
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_ld) begin
            for (int j = 0; j < 3; j++) begin
                cpt_reg[j] <= pin[j];
                ced_reg[j] <= 33'(pin[j]) - 33'(ppt_reg[j]);
            end
            crest_reg <= s_data.edge_rest_length;
            cvor_reg  <= s_data.voronoi_len;
            cstf_reg  <= s_data.stiffness;
            clast_reg <= s_data.is_last;
        end
        if (cmd.mac_en) acc_reg <= acc_next;
        if (cmd.den_ld) den_reg <= acc_abs[DEN_W-1:0];
        if (cmd.div_ld_k || cmd.div_ld_t) begin
            dvd_reg <= cmd.div_ld_k ? kdvd : tdvd;
            dsr_reg <= cmd.div_ld_k ? den_reg : DEN_W'(pvor_reg);
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= qbit ? DEN_W'(r2 - {1'b0, dsr_reg}) : r2[DEN_W-1:0];
            quo_reg <= {quo_reg[61:0], qbit};
        end
        if (cmd.k_st) k_reg[cmd.k_idx] <= k_sat ? '1 : quo_reg[KB_W-1:0];
        if (cmd.sq_ld) sq_reg <= acc_abs[SQ_W-1:0];
        if (cmd.out_ld) begin
            m_data_reg.energy <= esum_reg;
            m_data_reg.status <= flags_reg[1] ? ST_SAT : (flags_reg[0] ? ST_ZERO : ST_OK);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 3; j++) begin
                ppt_reg[j] <= '0;
                ped_reg[j] <= '0;
            end
            prest_reg   <= '0;
            pvor_reg    <= '0;
            pstf_reg    <= '0;
            esum_reg    <= '0;
            pseen_reg   <= '0;
            flags_reg   <= '0;
            qovf_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.div_ld_k || cmd.div_ld_t) qovf_reg <= 1'b0;
            else if (cmd.div_step) qovf_reg <= qovf_reg | quo_reg[62];
            if (cmd.flag_zero) flags_reg[0] <= 1'b1;
            if (cmd.k_st && k_sat) flags_reg[1] <= 1'b1;
            if (cmd.term_add) begin
                if (qovf_reg || sum_w[63]) begin
                    esum_reg     <= '1;
                    flags_reg[1] <= 1'b1;
                end else begin
                    esum_reg <= sum_w[62:0];
                end
            end
            if (cmd.state_upd) begin
                for (int j = 0; j < 3; j++) begin
                    ppt_reg[j] <= cpt_reg[j];
                    if (pseen_reg != 2'd0) ped_reg[j] <= ced_reg[j];
                end
                prest_reg <= crest_reg;
                pvor_reg  <= cvor_reg;
                pstf_reg  <= cstf_reg;
                if (pseen_reg != 2'd2) pseen_reg <= pseen_reg + 2'd1;
            end
            if (cmd.out_ld) begin
                // curve done: curve state back to its reset values, output valid raised
                for (int j = 0; j < 3; j++) begin
                    ppt_reg[j] <= '0;
                    ped_reg[j] <= '0;
                end
                prest_reg   <= '0;
                pvor_reg    <= '0;
                pstf_reg    <= '0;
                esum_reg    <= '0;
                pseen_reg   <= '0;
                flags_reg   <= '0;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.pseen    = pseen_reg;
        sts.cur_last = clast_reg;
        sts.skip     = (acc_reg == '0) || (pvor_reg == '0);
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ----- src/rbea_ctrl.sv -----
// Controller: sequences each point through the shared datapath
`default_nettype none
`include "rod_bending_energy_accumulator_top_assert.svh"
module rbea_ctrl
    import rbea_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam int KB_NW = kb_nw(FRAC_BITS);
    localparam int T_NW  = t_nw(FRAC_BITS);
    localparam int DIV_W = (KB_NW > T_NW) ? KB_NW : T_NW;
    localparam int CNT_W = $clog2(DIV_W);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_DEN  = 15'b000000000000010,
        S_CHK  = 15'b000000000000100,
        S_CRS  = 15'b000000000001000,
        S_DLDK = 15'b000000000010000,
        S_DIVK = 15'b000000000100000,
        S_KST  = 15'b000000001000000,
        S_SQ   = 15'b000000010000000,
        S_SQLD = 15'b000000100000000,
        S_NMUL = 15'b000001000000000,
        S_DLDT = 15'b000010000000000,
        S_DIVT = 15'b000100000000000,
        S_TADD = 15'b001000000000000,
        S_UPD  = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       j_reg, j_next;

    function automatic logic [1:0] rot(logic [1:0] j, logic [1:0] k);
        logic [2:0] s;
        s = {1'b0, j} + {1'b0, k};
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.in_ld  = 1'b1;
                    cnt_next   = '0;
                    state_next = (sts.pseen == 2'd2) ? S_DEN : S_UPD;
                end
            end
            S_DEN: begin
                // r0*r1 + a.b
                cmd.mac_en = 1'b1;
                cmd.a_sel  = OPD_PE;
                cmd.b_sel  = OPD_CE;
                unique case (cnt_reg[1:0])
                    2'd0: begin
                        cmd.a_sel   = OPD_PREST;
                        cmd.b_sel   = OPD_CREST;
                        cmd.mac_clr = 1'b1;
                    end
                    2'd1: begin cmd.a_idx = 2'd0; cmd.b_idx = 2'd0; end
                    2'd2: begin cmd.a_idx = 2'd1; cmd.b_idx = 2'd1; end
                    2'd3: begin cmd.a_idx = 2'd2; cmd.b_idx = 2'd2; end
                endcase
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg[1:0] == 2'd3) state_next = S_CHK;
            end
            S_CHK: begin
                cmd.den_ld = 1'b1;
                cnt_next   = '0;
                j_next     = 2'd0;
                if (sts.skip) begin
                    cmd.flag_zero = 1'b1;
                    state_next    = S_UPD;
                end else begin
                    state_next = S_CRS;
                end
            end
            S_CRS: begin
                cmd.mac_en = 1'b1;
                cmd.a_sel  = OPD_PE;
                cmd.b_sel  = OPD_CE;
                if (!cnt_reg[0]) begin
                    cmd.a_idx   = rot(j_reg, 2'd1);
                    cmd.b_idx   = rot(j_reg, 2'd2);
                    cmd.mac_clr = 1'b1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end else begin
                    cmd.a_idx   = rot(j_reg, 2'd2);
                    cmd.b_idx   = rot(j_reg, 2'd1);
                    cmd.mac_sub = 1'b1;
                    state_next  = S_DLDK;
                end
            end
            S_DLDK: begin
                cmd.div_ld_k = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIVK;
            end
            S_DIVK: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(KB_NW - 1)) state_next = S_KST;
            end
            S_KST: begin
                cmd.k_st  = 1'b1;
                cmd.k_idx = j_reg;
                cnt_next  = '0;
                if (j_reg == 2'd2) begin
                    j_next     = 2'd0;
                    state_next = S_SQ;
                end else begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_CRS;
                end
            end
            S_SQ: begin
                // k^2 from 20-bit halves
                cmd.mac_en = 1'b1;
                cmd.a_idx  = j_reg;
                cmd.b_idx  = j_reg;
                cmd.a_sel  = OPD_KHI;
                cmd.b_sel  = OPD_KHI;
                cmd.sh     = SH_40;
                priority if (cnt_reg[1:0] == 2'd0) begin
                    cmd.a_sel   = OPD_KLO;
                    cmd.b_sel   = OPD_KLO;
                    cmd.sh      = SH_0;
                    cmd.mac_clr = (j_reg == 2'd0);
                end else if (cnt_reg[1:0] == 2'd1) begin
                    cmd.a_sel = OPD_KLO;
                    cmd.sh    = SH_21;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg[1:0] == 2'd2) begin
                    cnt_next = '0;
                    if (j_reg == 2'd2) state_next = S_SQLD;
                    else j_next = j_reg + 2'd1;
                end
            end
            S_SQLD: begin
                cmd.sq_ld  = 1'b1;
                cnt_next   = '0;
                state_next = S_NMUL;
            end
            S_NMUL: begin
                cmd.mac_en = 1'b1;
                cmd.a_sel  = OPD_SQ;
                cmd.a_idx  = cnt_reg[1:0];
                cmd.b_sel  = OPD_STIFF;
                priority if (cnt_reg[1:0] == 2'd0) begin
                    cmd.sh      = SH_0;
                    cmd.mac_clr = 1'b1;
                end else if (cnt_reg[1:0] == 2'd1) begin
                    cmd.sh = SH_32;
                end else begin
                    cmd.sh = SH_64;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg[1:0] == 2'd2) state_next = S_DLDT;
            end
            S_DLDT: begin
                cmd.div_ld_t = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIVT;
            end
            S_DIVT: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(T_NW - 1)) state_next = S_TADD;
            end
            S_TADD: begin
                cmd.term_add = 1'b1;
                state_next   = S_UPD;
            end
            S_UPD: begin
                cmd.state_upd = 1'b1;
                state_next    = sts.cur_last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                // hold until the output register is free
                if (sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            j_reg     <= j_next;
        end
    end

    `RBEA_AST_IMP(a_divk_bound, aclk, aresetn, state_reg == S_DIVK, cnt_reg < CNT_W'(KB_NW), "curvature divide overran")
    `RBEA_AST_IMP(a_divt_bound, aclk, aresetn, state_reg == S_DIVT, cnt_reg < CNT_W'(T_NW), "term divide overran")
    `RBEA_AST_NXT(a_short_path, aclk, aresetn, s_valid && s_ready && sts.pseen != 2'd2, state_reg == S_UPD, "end point took the term path")
    `RBEA_AST_NXT(a_skip_path, aclk, aresetn, state_reg == S_CHK && sts.skip, state_reg == S_UPD, "zero divisor term not skipped")

endmodule
`default_nettype wire

// ----- src/rod_bending_energy_accumulator_top.sv -----
// Top level of the discrete rod bending energy accumulator
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | in_item_t  (one polyline point)
//   m_      | out       | m_valid / m_ready  | out_item_t (curve energy, status)
//
// First two points of a curve: accept, then state update.
// Interior point: denominator, three cross products each divided into a curvature,
// squares, stiffness product and energy divide, on the one-bit-per-cycle divider.
// A last point then loads the output register, which holds its item while the next
// curve is taken; the block waits there only if it is still full.
// Reset is synchronous, active low, and clears the curve state and the output valid.
`default_nettype none
module rod_bending_energy_accumulator_top
    import rbea_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    cmd_t cmd;
    sts_t sts;

    rbea_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rbea_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ----- test/rbea_checker.sv -----
// Bending energy checker: folds accepted points into predicted curve energies and compares
`default_nettype none
module rbea_checker
    import rbea_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_data,
    output int             errors,
    output int             pending
);

    localparam logic [127:0] MAX63  = {65'd0, {63{1'b1}}};
    localparam logic [127:0] KB_TOP = {88'd0, {40{1'b1}}};

    logic signed [127:0] last_pt [3];
    logic signed [127:0] last_edge [3];
    logic [127:0]        last_rest, last_vor, last_stiff, energy_acc;
    int                  npts;
    logic [1:0]          flags;
    out_item_t           curve_energy_q [$];
    int                  errs;

    function automatic logic [127:0] mag(input logic signed [127:0] v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic clear_curve();
        for (int j = 0; j < 3; j++) begin
            last_pt[j] = '0;
            last_edge[j] = '0;
        end
        last_rest = '0;
        last_vor = '0;
        last_stiff = '0;
        energy_acc = '0;
        npts = 0;
        flags = '0;
    endtask

    // Add the bending term of the previous vertex, with e as its outgoing edge
    task automatic add_bend(input logic signed [127:0] e [3], input logic [127:0] r1);
        logic signed [127:0] cr [3];
        logic signed [127:0] dot;
        logic [127:0]        den, q, rem, sumsq, n, term;
        int                  s;
        cr[0] = last_edge[1] * e[2] - last_edge[2] * e[1];
        cr[1] = last_edge[2] * e[0] - last_edge[0] * e[2];
        cr[2] = last_edge[0] * e[1] - last_edge[1] * e[0];
        dot = last_edge[0] * e[0] + last_edge[1] * e[1] + last_edge[2] * e[2];
        den = mag($signed(last_rest * r1) + dot);
        if (den == 0 || last_vor == 0) begin
            flags[0] = 1'b1;
            return;
        end
        sumsq = '0;
        for (int j = 0; j < 3; j++) begin
            q = (mag(cr[j]) << (FRAC_BITS + 1)) / den;
            if (q > KB_TOP) begin
                q = KB_TOP;
                flags[1] = 1'b1;
            end
            sumsq += q * q;
        end
        n = sumsq * last_stiff;
        s = 2 * FRAC_BITS - 32;
        if (s >= 0) begin
            q = (n >> s) / last_vor;
            if (q > MAX63) begin
                term = MAX63;
                flags[1] = 1'b1;
            end else begin
                term = q;
            end
        end else begin
            q = n / last_vor;
            rem = n % last_vor;
            if (q > (MAX63 >> (-s))) begin
                term = MAX63;
                flags[1] = 1'b1;
            end else begin
                term = (q << (-s)) + ((rem << (-s)) / last_vor);
            end
        end
        if (term > MAX63 - energy_acc) begin
            energy_acc = MAX63;
            flags[1] = 1'b1;
        end else begin
            energy_acc += term;
        end
    endtask

    task automatic fold_point(input in_item_t it);
        logic signed [127:0] p [3];
        logic signed [127:0] e [3];
        out_item_t           res;
        p[0] = $signed(it.pos_x);
        p[1] = $signed(it.pos_y);
        p[2] = $signed(it.pos_z);
        for (int j = 0; j < 3; j++) e[j] = p[j] - last_pt[j];
        if (npts >= 2) add_bend(e, {96'd0, it.edge_rest_length});
        if (npts >= 1) for (int j = 0; j < 3; j++) last_edge[j] = e[j];
        for (int j = 0; j < 3; j++) last_pt[j] = p[j];
        last_rest = {96'd0, it.edge_rest_length};
        last_vor = {96'd0, it.voronoi_len};
        last_stiff = {96'd0, it.stiffness};
        if (npts < 2) npts++;
        if (it.is_last) begin
            res.energy = energy_acc[62:0];
            res.status = flags[1] ? ST_SAT : (flags[0] ? ST_ZERO : ST_OK);
            curve_energy_q = {curve_energy_q, res};
            clear_curve();
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            clear_curve();
            curve_energy_q.delete();
            errs = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (curve_energy_q.size() == 0) begin
                    $error("result with no curve pending: energy %0h status %0d",
                           m_data.energy, m_data.status);
                    errs++;
                end else begin
                    want = curve_energy_q.pop_front();
                    if (m_data.energy !== want.energy) begin
                        $error("energy: expected %0h, got %0h", want.energy, m_data.energy);
                        errs++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready) fold_point(s_data);
        end
        errors <= errs;
        pending <= curve_energy_q.size();
    end

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench top: drives polyline points, paces the result side, gives the verdict
`default_nettype none
module testbench;
    import rbea_pkg::*;

    localparam int ONE   = 65536;
    localparam int LIMIT = 4000000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    int        errors;
    int        pending;
    int        n_sent = 0;
    bit        quiet = 1'b0;
    in_item_t  prev_pt = '0;

    rod_bending_energy_accumulator_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    rbea_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .errors(errors), .pending(pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (LIMIT) @(posedge aclk);
        $display("testbench: errors");
        $finish;
    end

    function automatic in_item_t pt(input int x, input int y, input int z,
                                    input logic [31:0] rest, input logic [31:0] vor,
                                    input logic [31:0] stiff, input logic last);
        in_item_t it;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.edge_rest_length = rest;
        it.voronoi_len = vor;
        it.stiffness = stiff;
        it.is_last = last;
        return it;
    endfunction

    task automatic send(input in_item_t it);
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        prev_pt = it;
    endtask

    // Drop valid for a random burst now and then
    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    function automatic int coord();
        return int'($urandom_range(0, 1 << 19)) - (1 << 18);
    endfunction

    function automatic in_item_t wild_point();
        in_item_t it;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.pos_z = $urandom;
        it.edge_rest_length = $urandom;
        it.voronoi_len = $urandom;
        it.stiffness = $urandom;
        it.is_last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic in_item_t tame_point(input logic last);
        in_item_t it;
        logic [31:0] vor;
        vor = ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom_range(1, 1 << 18));
        it = pt(coord(), coord(), coord(), $urandom_range(0, 1 << 18), vor,
                $urandom_range(0, 1 << 18), last);
        // repeat the previous point with zero rest length to hit a zero denominator
        if ($urandom_range(0, 19) == 0) begin
            it.pos_x = prev_pt.pos_x;
            it.pos_y = prev_pt.pos_y;
            it.pos_z = prev_pt.pos_z;
            it.edge_rest_length = '0;
        end
        return it;
    endfunction

    initial begin
        int len;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short curves
        send(pt(ONE, 0, 0, ONE, ONE, ONE, 1'b1));
        send(pt(0, 0, 0, ONE, ONE, ONE, 1'b0));
        send(pt(ONE, 0, 0, ONE, ONE, ONE, 1'b1));
        // straight line, then a right angle
        send(pt(0, 0, 0, ONE, ONE, ONE, 1'b0));
        send(pt(ONE, 0, 0, ONE, ONE, ONE, 1'b0));
        send(pt(2 * ONE, 0, 0, ONE, ONE, ONE, 1'b0));
        send(pt(2 * ONE, ONE, 0, ONE, ONE, ONE, 1'b1));
        // zero Voronoi length at the interior vertex
        send(pt(0, 0, 0, ONE, ONE, ONE, 1'b0));
        send(pt(ONE, 0, 0, ONE, 0, ONE, 1'b0));
        send(pt(ONE, ONE, 0, ONE, ONE, ONE, 1'b1));
        // perpendicular edges with zero rest lengths: zero denominator
        send(pt(0, 0, 0, 0, ONE, ONE, 1'b0));
        send(pt(0, ONE, 0, 0, ONE, ONE, 1'b0));
        send(pt(0, ONE, ONE, 0, ONE, ONE, 1'b1));
        // sharp turn back: negative denominator
        send(pt(0, 0, 0, ONE / 8, ONE, ONE, 1'b0));
        send(pt(ONE, 0, 0, ONE / 8, ONE, ONE, 1'b0));
        send(pt(0, ONE / 2, ONE / 4, ONE / 8, ONE, ONE, 1'b1));
        // extremes: huge curvature and stiffness over a tiny Voronoi length
        send(pt(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, '1, '1, '1, 1'b0));
        send(pt(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'd1, 32'd1, '1, 1'b0));
        send(pt(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'd1, '1, '1, 1'b0));
        send(pt(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'd0, 32'd0, 32'd0, 1'b1));
        send(pt(0, 0, 0, '1, '1, '1, 1'b0));
        send(pt(-1, 0, 1, '1, 32'd1, '1, 1'b0));
        send(pt(0, 1, 0, '1, '1, '1, 1'b1));

        while (n_sent < 1400) begin
            quiet = (n_sent >= 600 && n_sent < 750) || n_sent >= 1250;
            if ($urandom_range(0, 11) == 0) begin
                send(wild_point());
                maybe_idle();
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    send(tame_point(i == len - 1));
                    maybe_idle();
                end
            end
        end
        send(tame_point(1'b1));
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (600) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Result side: random stalls, one long hold-off, none near the end
    initial begin
        int  rx_gap;
        bit  held;
        rx_gap = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (!held && n_sent >= 300) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/rbea_pkg.sv
src/rbea_datapath.sv
src/rbea_ctrl.sv
src/rod_bending_energy_accumulator_top.sv
test/rbea_checker.sv
test/testbench.sv
